@@ rtl/core/bcdl_pkg.sv @@
package bcdl_pkg;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        ST_UP        = 2'd0,
        ST_PRESS_BNC = 2'd1,
        ST_DOWN      = 2'd2,
        ST_REL_BNC   = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW   = 2'd2;

    localparam t_cnt SCAN_PERIOD_RST = 16'd10;
    localparam t_cnt LONG_TIME_RST   = 16'd1000;
    localparam t_cnt DBL_WINDOW_RST  = 16'd300;

    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + t_cnt'(1);
    endfunction

endpackage

@@ rtl/core/bcdl_in_if.sv @@
interface bcdl_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

@@ rtl/core/bcdl_out_if.sv @@
interface bcdl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

@@ rtl/core/button_click_double_long_detector.sv @@
// channel   dir  payload              beat when
// i_in      in   pin_level [0:0]      i_in.valid & i_in.ready
// o_out     out  event_res [1:0]      o_out.valid & o_out.ready
// i_cfg_*   in   idx [1:0], data [15:0]  i_cfg_we
//
// One tick per cycle while i_in.ready is high; each tick's event is registered.
// All counter and debounce updates happen in the accept cycle, so ticks
// may arrive back to back; a one-entry skid register behind the output
// register keeps i_in.ready high for one extra beat while o_out stalls.
// Reset (i_rst_n low, synchronous) loads the default periods, puts the
// machine in the up state and clears counters and both output entries.
module button_click_double_long_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bcdl_in_if.sink                       i_in,
    bcdl_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [bcdl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcdl_pkg::CNT_W-1:0]    i_cfg_data
);

    bcdl_pkg::t_cnt   r_scan_period, r_long_time, r_dbl_window;
    bcdl_pkg::t_state r_state, n_state;
    bcdl_pkg::t_cnt   r_scan, r_hold, r_win;
    bcdl_pkg::t_cnt   n_hold, n_win;
    logic             r_pending, n_pending;
    logic             r_long, n_long;
    bcdl_pkg::t_event n_event;

    logic             r_out_valid, r_skid_valid;
    bcdl_pkg::t_event r_out_event, r_skid_event;

    logic           accept, out_fire, step, high;
    bcdl_pkg::t_cnt scan_inc, hold_inc, win_inc;

    assign accept   = i_in.valid & i_in.ready;
    assign out_fire = r_out_valid & o_out.ready;
    assign high     = i_in.pin_level;

    assign scan_inc = bcdl_pkg::sat_inc(r_scan);
    assign hold_inc = bcdl_pkg::sat_inc(r_hold);
    assign win_inc  = bcdl_pkg::sat_inc(r_win);
    assign step     = accept & (scan_inc >= r_scan_period);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period <= bcdl_pkg::SCAN_PERIOD_RST;
            r_long_time   <= bcdl_pkg::LONG_TIME_RST;
            r_dbl_window  <= bcdl_pkg::DBL_WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcdl_pkg::CFG_SCAN_PERIOD: r_scan_period <= i_cfg_data;
                bcdl_pkg::CFG_LONG_TIME:   r_long_time   <= i_cfg_data;
                bcdl_pkg::CFG_DBL_WINDOW:  r_dbl_window  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (step) begin
            case (r_state)
                bcdl_pkg::ST_UP: begin
                    if (!high) n_state = bcdl_pkg::ST_PRESS_BNC;
                end
                bcdl_pkg::ST_PRESS_BNC: begin
                    n_state = high ? bcdl_pkg::ST_UP : bcdl_pkg::ST_DOWN;
                end
                bcdl_pkg::ST_DOWN: begin
                    if (high || (!r_long && hold_inc >= r_long_time))
                        n_state = bcdl_pkg::ST_REL_BNC;
                end
                bcdl_pkg::ST_REL_BNC: begin
                    if (high) n_state = bcdl_pkg::ST_UP;
                end
                default: n_state = bcdl_pkg::ST_UP;
            endcase
        end
    end

    // event and counters
    always_comb begin
        n_event   = bcdl_pkg::EV_NONE;
        n_hold    = hold_inc;
        n_win     = win_inc;
        n_pending = r_pending;
        n_long    = r_long;
        if (step) begin
            case (r_state)
                bcdl_pkg::ST_UP: begin
                    if (high && r_pending && win_inc >= r_dbl_window) begin
                        n_event   = bcdl_pkg::EV_SINGLE;
                        n_pending = 1'b0;
                    end
                end
                bcdl_pkg::ST_PRESS_BNC: begin
                    if (!high) begin
                        n_hold = '0;
                        n_long = 1'b0;
                    end
                end
                bcdl_pkg::ST_DOWN: begin
                    if (high) begin
                        if (!r_long) begin
                            if (r_pending) begin
                                n_event   = bcdl_pkg::EV_DOUBLE;
                                n_pending = 1'b0;
                            end else begin
                                n_pending = 1'b1;
                                n_win     = '0;
                            end
                        end
                    end else if (!r_long && hold_inc >= r_long_time) begin
                        n_event   = bcdl_pkg::EV_LONG;
                        n_long    = 1'b1;
                        n_pending = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bcdl_pkg::ST_UP;
            r_scan    <= '0;
            r_hold    <= '0;
            r_win     <= '0;
            r_pending <= 1'b0;
            r_long    <= 1'b0;
        end else if (accept) begin
            r_state   <= n_state;
            r_scan    <= step ? '0 : scan_inc;
            r_hold    <= n_hold;
            r_win     <= n_win;
            r_pending <= n_pending;
            r_long    <= n_long;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_out_event  <= r_skid_event;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_out_event <= n_event;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out_event <= n_event;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_event <= n_event;
            end
        end
    end

    assign i_in.ready      = ~r_skid_valid;
    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state) && $stable(r_hold) && $stable(r_pending))
        else $error("machine state moved without a beat");

    a_long_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_event == bcdl_pkg::EV_LONG)
            |=> r_long && !r_pending && r_state == bcdl_pkg::ST_REL_BNC)
        else $error("long press did not mark release-bounce");

    a_double_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_event == bcdl_pkg::EV_DOUBLE) |=> !r_pending)
        else $error("double click left a click pending");

endmodule
